// ===== sv/aufs_pkg.sv =====
// shared types, constants and helper functions for the angle unwrap and force smoother
// depends on nothing; imported by every module of the block
`default_nettype none

package aufs_pkg;

  // field widths
  localparam int unsigned AngleW    = 12;
  localparam int unsigned ForceW    = 24;
  localparam int unsigned OutAngleW = 16;
  localparam int unsigned TurnW     = 4;
  localparam int unsigned AvgW      = 40;
  localparam int unsigned FracW     = 16;
  localparam int unsigned LimitW    = 14;
  localparam int unsigned GainW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // turn offset saturates at plus and minus this many turns
  localparam logic signed [TurnW-1:0] MaxTurns = 4'sd6;

  // half a turn in counts, for jump detection
  localparam logic signed [AngleW:0] HalfTurn = 13'sd2048;

  // register reset values
  localparam logic [LimitW-1:0] UpperReset = 14'd6826;
  localparam logic [LimitW-1:0] LowerReset = 14'd1138;
  localparam logic [GainW-1:0]  GainReset  = 16'd3277;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgUpper = 2'd0,
    CfgLower = 2'd1,
    CfgGain  = 2'd2
  } cfg_idx_e;

  // current register values
  typedef struct packed {
    logic [LimitW-1:0] upper_limit;
    logic [LimitW-1:0] lower_limit;
    logic [GainW-1:0]  smoothing_gain;
  } cfg_t;

  // one turn down, held at the negative limit
  function automatic logic signed [TurnW-1:0] turn_dec(input logic signed [TurnW-1:0] t);
    if (t == -MaxTurns) begin
      return t;
    end
    return t - 4'sd1;
  endfunction

  // one turn up, held at the positive limit
  function automatic logic signed [TurnW-1:0] turn_inc(input logic signed [TurnW-1:0] t);
    if (t == MaxTurns) begin
      return t;
    end
    return t + 4'sd1;
  endfunction

  // raw angle plus 4096 counts per turn of offset
  function automatic logic signed [OutAngleW-1:0] unwrap_calc(
    input logic [AngleW-1:0]        angle,
    input logic signed [TurnW-1:0]  turns
  );
    logic [OutAngleW-1:0] sum;
    sum = {turns, {AngleW{1'b0}}} + {{(OutAngleW-AngleW){1'b0}}, angle};
    return $signed(sum);
  endfunction

endpackage : aufs_pkg

`default_nettype wire

// ===== sv/angle_unwrap_force_smoother.sv =====
// Angle unwrap and force smoother, top level.
// Input stream: one transfer per sensor sample. tdata carries the 12-bit
// absolute angle and the signed 24-bit force; tuser carries the clear flag
// that drops the previous angle and the turn offset before this sample.
// Output stream: one transfer per input transfer, in order, carrying the
// signed 16-bit unwrapped angle and the rounded signed 24-bit force average.
// Configuration channel: index 0 upper window limit, 1 lower window limit,
// 2 smoothing gain (Q0.16); other indexes are accepted and ignored. Write it
// only while no sample is in flight.
// Path: each sample is held in the input register, then in the result
// register. Throughput: one sample per cycle while m_axis_tready stays high;
// the whole unwrap and the multiply-accumulate of the average sit between
// those two registers, and the per-sample state updates there.
// Reset: window limits and gain return to their defaults, the previous angle,
// turn offset and average are forgotten, both registers are emptied.
// Stall: the result register holds while tready is low; the input register
// still takes one more sample, after which s_axis_tready falls.
// depends on aufs_pkg, aufs_cfg, aufs_unwrap, aufs_ema
`default_nettype none

module angle_unwrap_force_smoother (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [39:0]                    s_axis_tdata,  // sample_angle[11:0], sample_force[35:12]
  input  wire logic                           s_axis_tuser,  // clear_unwrap[0]
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [39:0]                         m_axis_tdata,  // unwrapped_angle[15:0], smoothed_force[39:16]
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [aufs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [aufs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import aufs_pkg::*;

  cfg_t cfg;

  // input register
  logic                     in_valid_q, in_valid_d;
  logic                     in_clear_q;
  logic [AngleW-1:0]        in_angle_q;
  logic signed [ForceW-1:0] in_force_q;

  // result register
  logic                        out_valid_q, out_valid_d;
  logic signed [OutAngleW-1:0] out_angle_q;
  logic signed [ForceW-1:0]    out_force_q;

  logic                        in_take;
  logic                        advance;
  logic signed [OutAngleW-1:0] unwrapped;
  logic signed [ForceW-1:0]    filtered;

  aufs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake: item moves on when the result register is free or emptying
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  assign in_valid_d  = in_take | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~m_axis_tready);

  aufs_unwrap u_unwrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .clear_i     (in_clear_q),
    .angle_i     (in_angle_q),
    .cfg_i       (cfg),
    .unwrapped_o (unwrapped)
  );

  aufs_ema u_ema (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .force_i    (in_force_q),
    .gain_i     (cfg.smoothing_gain),
    .filtered_o (filtered)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_clear_q <= s_axis_tuser;
      in_angle_q <= s_axis_tdata[AngleW-1:0];
      in_force_q <= $signed(s_axis_tdata[AngleW+ForceW-1:AngleW]);
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_angle_q <= unwrapped;
      out_force_q <= filtered;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_force_q, out_angle_q};

endmodule : angle_unwrap_force_smoother

`default_nettype wire

// ===== sv/aufs_cfg.sv =====
// configuration registers: window limits and smoothing gain
// depends on aufs_pkg
`default_nettype none

module aufs_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [aufs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [aufs_pkg::CfgDataW-1:0]   cfg_data_i,
  output aufs_pkg::cfg_t                       cfg_o
);
  import aufs_pkg::*;

  cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgUpper: cfg_d.upper_limit    = cfg_data_i[LimitW-1:0];
        CfgLower: cfg_d.lower_limit    = cfg_data_i[LimitW-1:0];
        CfgGain:  cfg_d.smoothing_gain = cfg_data_i[GainW-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_limit    <= UpperReset;
      cfg_q.lower_limit    <= LowerReset;
      cfg_q.smoothing_gain <= GainReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : aufs_cfg

`default_nettype wire

// ===== sv/aufs_unwrap.sv =====
// angle unwrap: jump detection, saturating turn offset and window pull-back
// depends on aufs_pkg
`default_nettype none

module aufs_unwrap (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   advance_i,
  input  wire logic                                   clear_i,
  input  wire logic [aufs_pkg::AngleW-1:0]            angle_i,
  input  wire aufs_pkg::cfg_t                         cfg_i,
  output logic signed [aufs_pkg::OutAngleW-1:0]       unwrapped_o
);
  import aufs_pkg::*;

  logic [AngleW-1:0]       last_angle_q;
  logic                    last_valid_q;
  logic signed [TurnW-1:0] turns_q, turns_d;

  logic                    valid0;
  logic signed [TurnW-1:0] off0, off1, off2;
  logic signed [AngleW:0]  diff;
  logic signed [OutAngleW-1:0] u1, u2, u3;
  logic signed [OutAngleW:0]   upper_ext, lower_ext;

  assign upper_ext = $signed({3'b000, cfg_i.upper_limit});
  assign lower_ext = $signed({3'b000, cfg_i.lower_limit});

  // clear forgets the previous angle and the offset
  assign valid0 = last_valid_q & ~clear_i;
  assign off0   = clear_i ? '0 : turns_q;

  always_comb begin
    // jump against the previous sample, none on the first one
    if (valid0) begin
      diff = $signed({1'b0, angle_i}) - $signed({1'b0, last_angle_q});
    end else begin
      diff = '0;
    end
    if (diff > HalfTurn) begin
      off1 = turn_dec(off0);
    end else if (diff < -HalfTurn) begin
      off1 = turn_inc(off0);
    end else begin
      off1 = off0;
    end

    // pull down when above the window
    u1 = unwrap_calc(angle_i, off1);
    if ($signed({u1[OutAngleW-1], u1}) > upper_ext) begin
      off2 = turn_dec(off1);
    end else begin
      off2 = off1;
    end

    // then pull up when below it
    u2 = unwrap_calc(angle_i, off2);
    if ($signed({u2[OutAngleW-1], u2}) < lower_ext) begin
      turns_d = turn_inc(off2);
    end else begin
      turns_d = off2;
    end
    u3 = unwrap_calc(angle_i, turns_d);
  end

  assign unwrapped_o = u3;

  // state moves on each item handed to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_angle_q <= '0;
      last_valid_q <= 1'b0;
      turns_q      <= '0;
    end else if (advance_i) begin
      last_angle_q <= angle_i;
      last_valid_q <= 1'b1;
      turns_q      <= turns_d;
    end
  end

endmodule : aufs_unwrap

`default_nettype wire

// ===== sv/aufs_ema.sv =====
// force moving average with Q0.16 gain and rounded output
// depends on aufs_pkg
`default_nettype none

module aufs_ema (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  advance_i,
  input  wire logic signed [aufs_pkg::ForceW-1:0]    force_i,
  input  wire logic [aufs_pkg::GainW-1:0]            gain_i,
  output logic signed [aufs_pkg::ForceW-1:0]         filtered_o
);
  import aufs_pkg::*;

  logic signed [AvgW-1:0] avg_q, avg_d;
  logic                   seeded_q;

  logic signed [AvgW-1:0]    seed;
  logic signed [AvgW:0]      diff;
  logic signed [AvgW-FracW:0] diff_hi;
  logic [FracW-1:0]          diff_lo;
  logic signed [AvgW+1:0]    prod_hi;
  logic [2*FracW-1:0]        prod_lo;
  logic signed [AvgW+1:0]    incr;
  logic signed [AvgW+1:0]    avg_sum;
  logic [AvgW-1:0]           rounded;

  assign seed = {force_i, {FracW{1'b0}}};

  // difference between sample and average, split at the binary point
  assign diff    = $signed({force_i[ForceW-1], force_i, {FracW{1'b0}}})
                 - $signed({avg_q[AvgW-1], avg_q});
  assign diff_hi = diff[AvgW:FracW];
  assign diff_lo = diff[FracW-1:0];

  // gain times difference as two partial products
  // low product plus the rounding half stays below 2^32
  assign prod_hi = diff_hi * $signed({1'b0, gain_i});
  assign prod_lo = diff_lo * gain_i + (32'd1 << (FracW-1));
  assign incr    = prod_hi + $signed({{(AvgW+2-FracW){1'b0}}, prod_lo[2*FracW-1:FracW]});
  assign avg_sum = $signed({{2{avg_q[AvgW-1]}}, avg_q}) + incr;

  // first sample seeds the average
  assign avg_d = seeded_q ? avg_sum[AvgW-1:0] : seed;

  // round half up to whole counts
  assign rounded    = avg_d + (40'd1 << (FracW-1));
  assign filtered_o = $signed(rounded[AvgW-1:FracW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q    <= '0;
      seeded_q <= 1'b0;
    end else if (advance_i) begin
      avg_q    <= avg_d;
      seeded_q <= 1'b1;
    end
  end

endmodule : aufs_ema

`default_nettype wire

// ===== test/tb_angle_unwrap_force_smoother.sv =====
// self-checking testbench for angle_unwrap_force_smoother: streams samples in, checks each result
// against a local predictor of the angle unwrap and force average; depends on aufs_pkg and the rtl
module tb_angle_unwrap_force_smoother;
  timeunit 1ns;
  timeprecision 1ps;

  import aufs_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 6;
  localparam int TurnCounts  = 4096;
  localparam int ReportLimit = 10;

  // one result as the block should present it
  typedef struct packed {
    logic [OutAngleW-1:0] unwrapped_angle;
    logic [ForceW-1:0]    smoothed_force;
  } sample_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata = '0;  // sample_angle[11:0], sample_force[35:12]
  logic                s_axis_tuser = 1'b0;  // clear_unwrap[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;  // unwrapped_angle[15:0], smoothed_force[39:16]
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor state and its copy of the registers
  logic [AngleW-1:0] last_seen_angle = '0;
  bit                last_seen_valid = 1'b0;
  int                turn_count = 0;
  longint            force_acc = 0;
  bit                force_seeded = 1'b0;
  logic [LimitW-1:0] upper_lim = UpperReset;
  logic [LimitW-1:0] lower_lim = LowerReset;
  logic [GainW-1:0]  ema_gain = GainReset;

  sample_result_t awaited_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  angle_unwrap_force_smoother dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int clamp_turns(input int t);
    if (t > int'(MaxTurns)) return int'(MaxTurns);
    if (t < -int'(MaxTurns)) return -int'(MaxTurns);
    return t;
  endfunction

  // unwrap, window pull-back and moving average for one accepted sample
  function automatic void predict_unwrap_and_average(input bit clr,
                                                     input logic [AngleW-1:0] ang,
                                                     input logic signed [ForceW-1:0] frc);
    int             diff;
    int             unwrapped;
    longint         scaled;
    longint         weighted;
    longint         rounded;
    sample_result_t res;
    if (clr) begin
      last_seen_valid = 1'b0;
      turn_count = 0;
    end
    if (!last_seen_valid) begin
      last_seen_angle = ang;
      last_seen_valid = 1'b1;
    end
    // half-turn jump moves the offset against the jump
    diff = int'(ang) - int'(last_seen_angle);
    if (diff > int'(HalfTurn)) turn_count = clamp_turns(turn_count - 1);
    else if (diff < -int'(HalfTurn)) turn_count = clamp_turns(turn_count + 1);
    last_seen_angle = ang;
    // window: upper check first, lower check sees its result
    unwrapped = int'(ang) + turn_count * TurnCounts;
    if (unwrapped > int'(upper_lim)) begin
      turn_count = clamp_turns(turn_count - 1);
      unwrapped = int'(ang) + turn_count * TurnCounts;
    end
    if (unwrapped < int'(lower_lim)) begin
      turn_count = clamp_turns(turn_count + 1);
      unwrapped = int'(ang) + turn_count * TurnCounts;
    end
    // average with 16 fraction bits, seeded by the first sample
    scaled = longint'(frc) * 65536;
    if (!force_seeded) begin
      force_acc = scaled;
      force_seeded = 1'b1;
    end else begin
      weighted = longint'(ema_gain) * (scaled - force_acc) + 64'sd32768;
      force_acc = force_acc + (weighted >>> 16);
    end
    rounded = (force_acc + 64'sd32768) >>> 16;
    res.unwrapped_angle = unwrapped[OutAngleW-1:0];
    res.smoothed_force = rounded[ForceW-1:0];
    awaited_results.push_back(res);
  endfunction

  function automatic void log_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    sample_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        log_mismatch("unexpected result, angle", 0, $signed(m_axis_tdata[15:0]));
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata[15:0] !== want.unwrapped_angle) begin
          log_mismatch("unwrapped_angle", $signed(want.unwrapped_angle),
                       $signed(m_axis_tdata[15:0]));
        end
        if (m_axis_tdata[39:16] !== want.smoothed_force) begin
          log_mismatch("smoothed_force", $signed(want.smoothed_force),
                       $signed(m_axis_tdata[39:16]));
        end
      end
    end
  end

  // one sample transfer, with a random gap in front of it
  task automatic send_sample(input bit clr, input logic [AngleW-1:0] ang,
                             input logic [ForceW-1:0] frc);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, frc, ang};
    s_axis_tuser <= clr;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_unwrap_and_average(clr, ang, frc);
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all three registers back to back while the block is idle
  task automatic set_window_and_gain(input logic [LimitW-1:0] up, input logic [LimitW-1:0] lo,
                                     input logic [GainW-1:0] gain);
    cfg_idx_e         idx [3];
    logic [15:0]      val [3];
    idx = '{CfgUpper, CfgLower, CfgGain};
    val = '{{2'b0, up}, {2'b0, lo}, gain};
    wait_results_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    upper_lim = up;
    lower_lim = lo;
    ema_gain = gain;
  endtask

  // seed, extreme forces, jumps of exactly and just over half a turn, clear flag
  task automatic test_directed_unwrap();
    send_sample(1'b0, 12'd0, 24'd0);
    send_sample(1'b0, 12'd4095, 24'h7FFFFF);
    send_sample(1'b0, 12'd2047, 24'h800000);
    send_sample(1'b0, 12'd4095, 24'h800000);
    send_sample(1'b0, 12'd2047, 24'h7FFFFF);
    send_sample(1'b0, 12'd0, 24'd1);
    send_sample(1'b0, 12'd2049, 24'hFFFFFF);
    send_sample(1'b0, 12'd0, 24'd2);
    send_sample(1'b1, 12'd3000, 24'd100);
    send_sample(1'b1, 12'd3000, 24'd100);
    send_sample(1'b0, 12'd1000, 24'hFFFF9C);
  endtask

  // gain extremes, contradictory window, several turns forward then back
  task automatic test_window_and_gain();
    logic [AngleW-1:0] ang;
    set_window_and_gain(14'd16383, 14'd0, 16'd0);
    send_sample(1'b0, 12'd4000, 24'd1234);
    send_sample(1'b0, 12'd100, 24'hFFEC78);
    send_sample(1'b0, 12'd10, 24'h800000);
    set_window_and_gain(14'd0, 14'd16383, 16'hFFFF);
    send_sample(1'b0, 12'd2048, 24'd77);
    send_sample(1'b0, 12'd4095, 24'hFFFFB3);
    send_sample(1'b0, 12'd0, 24'h7FFFFF);
    set_window_and_gain(14'd16383, 14'd0, GainReset);
    ang = 12'd0;
    for (int i = 0; i < 8; i++) begin
      ang = ang + 12'd1500;
      send_sample(1'b0, ang, 24'(i * 100000));
    end
    for (int i = 0; i < 4; i++) begin
      ang = ang - 12'd1900;
      send_sample(1'b0, ang, 24'h800000);
    end
  endtask

  // continuous rotation with random content, plus large jumps and clears
  task automatic send_rotation_run(input int count);
    logic [AngleW-1:0] ang;
    logic [ForceW-1:0] frc;
    int                roll;
    int                step;
    bit                clr;
    ang = 12'($urandom);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      clr = ($urandom_range(99) < 4);
      if (roll < 78) step = int'($urandom_range(3800)) - 1900;
      else if (roll < 88) step = ($urandom_range(1) ? 1 : -1) * int'(2040 + $urandom_range(16));
      else step = int'($urandom_range(4095));
      ang = ang + 12'(step);
      roll = $urandom_range(99);
      if (roll < 10) frc = 24'h7FFFFF;
      else if (roll < 20) frc = 24'h800000;
      else frc = 24'($urandom);
      send_sample(clr, ang, frc);
    end
  endtask

  task automatic random_window_and_gain();
    logic [LimitW-1:0] up;
    logic [LimitW-1:0] lo;
    up = 14'($urandom_range(16383));
    lo = 14'($urandom_range(16383));
    case ($urandom_range(3))
      0: set_window_and_gain(up, lo, 16'($urandom));
      1: set_window_and_gain(UpperReset, LowerReset, GainReset);
      2: set_window_and_gain(14'd16383, 14'd0, 16'($urandom_range(1) ? 16'hFFFF : 16'd1));
      default: set_window_and_gain(up > lo ? up : lo, up > lo ? lo : up, 16'($urandom));
    endcase
  endtask

  // random traffic under each idling pattern, registers changed before each pair of runs
  task automatic test_random_traffic();
    int gaps [4];
    int stalls [4];
    gaps = '{0, 49, 0, 7};
    stalls = '{0, 0, 49, 7};
    for (int p = 0; p < 4; p++) begin
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      for (int r = 0; r < 3; r++) begin
        random_window_and_gain();
        send_rotation_run(50);
        // sender holds off until everything is back, then carries on
        wait_results_drained();
        send_rotation_run(50);
      end
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_unwrap();
    test_window_and_gain();
    test_random_traffic();
    wait_results_drained();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/aufs_pkg.sv
sv/aufs_cfg.sv
sv/aufs_unwrap.sv
sv/aufs_ema.sv
sv/angle_unwrap_force_smoother.sv
test/tb_angle_unwrap_force_smoother.sv
